// ===== sv/scp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and command codes for the sound-chip command parser.
package scp_pkg;

    // Command bytes that open a frame
    localparam logic [7:0] CMD_SCC = 8'hD2;
    localparam logic [7:0] CMD_AY  = 8'hA0;
    localparam logic [7:0] CMD_SN  = 8'h50;
    localparam logic [7:0] CMD_VAR = 8'h51;
    localparam logic [7:0] CMD_GB  = 8'hB3;
    localparam logic [7:0] CMD_NES = 8'hB4;
    localparam logic [7:0] PORT_MASK = 8'h7F;

    // Active flag positions
    localparam int FLAG_SCC = 0;
    localparam int FLAG_AY  = 1;
    localparam int FLAG_SN  = 2;
    localparam int FLAG_GB  = 3;
    localparam int FLAG_NES = 4;
    localparam int FLAG_W   = 5;

    // Result queue
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        K_IDLE = 3'd0,
        K_SCC  = 3'd1,
        K_AY   = 3'd2,
        K_SN   = 3'd3,
        K_VAR  = 3'd4,
        K_GB   = 3'd5,
        K_NES  = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        TGT_SCC = 3'd0,
        TGT_AY  = 3'd1,
        TGT_SN  = 3'd2,
        TGT_VAR = 3'd3,
        TGT_GB  = 3'd4,
        TGT_NES = 3'd5
    } t_target;

    typedef struct packed {
        logic [2:0]        target;
        logic [7:0]        reg_addr;
        logic [7:0]        write_data;
        logic [FLAG_W-1:0] active_mask;
        logic              last_write;
    } t_result;

    // Up to two result words produced by one received byte
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

// ===== sv/sound_chip_command_parser_unit.sv =====
`timescale 1ns / 1ps
// Sound-chip command parser: top level with stream ports.
// Result words: the words of a byte are registered into the result queue as that byte is taken;
// the second write of an SCC pair is queued behind the first and leaves after it.
// Throughput: one byte per cycle; tready drops only while the four-word result queue
// has fewer than two free slots, which a stalled master side causes.
// Reset: synchronous, active low; clears the frame state, active flags and result queue.
module sound_chip_command_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] reg_addr, [15:8] write_data,
                                          // [20:16] active_mask, [23:21] zero
    output logic [2:0]  o_m_axis_tuser,   // [2:0] target
    output logic        o_m_axis_tlast    // last_write
);
    import scp_pkg::*;

    t_push   w_push;
    t_result w_head;
    logic    w_room2;
    logic    w_accept;

    assign o_s_axis_tready = w_room2;
    assign w_accept        = i_s_axis_tvalid && w_room2;

    scp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_byte  (i_s_axis_tdata),
        .o_push  (w_push)
    );

    scp_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_head  (w_head),
        .o_room2 (w_room2)
    );

    assign o_m_axis_tdata = {3'b000, w_head.active_mask, w_head.write_data, w_head.reg_addr};
    assign o_m_axis_tuser = w_head.target;
    assign o_m_axis_tlast = w_head.last_write;

endmodule

// ===== sv/scp_parser.sv =====
`timescale 1ns / 1ps
// Frame state machine: decodes one received byte per cycle into result words.
module scp_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    output scp_pkg::t_push o_push
);
    import scp_pkg::*;

    t_kind             r_kind, n_kind;
    logic [1:0]        r_left, n_left;
    logic [6:0]        r_port, n_port;
    logic [7:0]        r_reg,  n_reg;
    logic [FLAG_W-1:0] r_flags, n_flags;
    logic              w_start;

    // A byte is a command byte when no well-formed frame is open
    always_comb begin
        w_start = !(r_kind inside {K_SCC, K_AY, K_SN, K_VAR, K_GB, K_NES}) || (r_left == 2'd0);
    end

    // Next state
    always_comb begin
        n_kind  = r_kind;
        n_left  = r_left;
        n_port  = r_port;
        n_reg   = r_reg;
        n_flags = r_flags;
        if (i_valid) begin
            if (w_start) begin
                n_kind = K_IDLE;
                n_left = 2'd0;
                case (i_byte)
                    CMD_SCC: begin
                        n_flags[FLAG_SCC] = 1'b1;
                        n_kind = K_SCC;
                        n_left = 2'd3;
                    end
                    CMD_AY: begin
                        n_flags[FLAG_AY] = 1'b1;
                        n_kind = K_AY;
                        n_left = 2'd2;
                    end
                    CMD_SN: begin
                        n_flags[FLAG_SN] = 1'b1;
                        n_kind = K_SN;
                        n_left = 2'd1;
                    end
                    CMD_VAR: begin
                        n_kind = K_VAR;
                        n_left = 2'd1;
                    end
                    CMD_GB: begin
                        n_flags[FLAG_GB] = 1'b1;
                        n_kind = K_GB;
                        n_left = 2'd2;
                    end
                    CMD_NES: begin
                        n_flags[FLAG_NES] = 1'b1;
                        n_kind = K_NES;
                        n_left = 2'd2;
                    end
                    default: begin
                    end
                endcase
            end else begin
                case (r_kind)
                    K_SCC: begin
                        if (r_left == 2'd3) begin
                            n_port = 7'(i_byte & PORT_MASK);
                            n_left = 2'd2;
                        end else if (r_left == 2'd2) begin
                            n_reg  = i_byte;
                            n_left = 2'd1;
                        end else begin
                            n_kind = K_IDLE;
                            n_left = 2'd0;
                        end
                    end
                    K_AY, K_GB, K_NES: begin
                        if (r_left >= 2'd2) begin
                            n_reg  = i_byte;
                            n_left = 2'd1;
                        end else begin
                            n_kind = K_IDLE;
                            n_left = 2'd0;
                        end
                    end
                    default: begin
                        n_kind = K_IDLE;
                        n_left = 2'd0;
                    end
                endcase
            end
        end
    end

    // Result words
    always_comb begin
        o_push = '0;
        if (i_valid && !w_start) begin
            case (r_kind)
                K_SCC: begin
                    if (r_left == 2'd1) begin
                        o_push.cnt              = 2'd2;
                        o_push.res0.target      = TGT_SCC;
                        o_push.res0.reg_addr    = {r_port, 1'b0};
                        o_push.res0.write_data  = r_reg;
                        o_push.res0.active_mask = r_flags;
                        o_push.res0.last_write  = 1'b0;
                        o_push.res1.target      = TGT_SCC;
                        o_push.res1.reg_addr    = {r_port, 1'b1};
                        o_push.res1.write_data  = i_byte;
                        o_push.res1.active_mask = r_flags;
                        o_push.res1.last_write  = 1'b1;
                    end
                end
                K_SN, K_VAR: begin
                    o_push.cnt              = 2'd1;
                    o_push.res0.target      = (r_kind == K_SN) ? TGT_SN : TGT_VAR;
                    o_push.res0.reg_addr    = 8'd0;
                    o_push.res0.write_data  = i_byte;
                    o_push.res0.active_mask = r_flags;
                    o_push.res0.last_write  = 1'b1;
                end
                K_AY, K_GB, K_NES: begin
                    if (r_left == 2'd1) begin
                        o_push.cnt              = 2'd1;
                        o_push.res0.target      = (r_kind == K_AY) ? TGT_AY :
                                                  (r_kind == K_GB) ? TGT_GB : TGT_NES;
                        o_push.res0.reg_addr    = r_reg;
                        o_push.res0.write_data  = i_byte;
                        o_push.res0.active_mask = r_flags;
                        o_push.res0.last_write  = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= K_IDLE;
            r_left  <= 2'd0;
            r_port  <= 7'd0;
            r_reg   <= 8'd0;
            r_flags <= '0;
        end else begin
            r_kind  <= n_kind;
            r_left  <= n_left;
            r_port  <= n_port;
            r_reg   <= n_reg;
            r_flags <= n_flags;
        end
    end

endmodule

// ===== sv/scp_result_fifo.sv =====
`timescale 1ns / 1ps
// Small result queue: takes up to two words a cycle, hands out one.
module scp_result_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  scp_pkg::t_push  i_push,
    input  logic            i_pop,
    output logic            o_valid,
    output scp_pkg::t_result o_head,
    output logic            o_room2
);
    import scp_pkg::*;

    t_result          r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, n_wp;
    logic [QAW-1:0]   r_rp, n_rp;
    logic [QAW:0]     r_cnt, n_cnt;
    logic             w_pop;
    logic [QAW-1:0]   w_wp1;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];
    assign o_room2 = (r_cnt <= (QAW+1)'(QDEPTH - 2));
    assign w_pop   = i_pop && o_valid;
    assign w_wp1   = r_wp + QAW'(1);

    always_comb begin
        n_wp  = r_wp + QAW'(i_push.cnt);
        n_rp  = r_rp + QAW'(w_pop);
        n_cnt = r_cnt + (QAW+1)'(i_push.cnt) - (QAW+1)'(w_pop);
    end

    // Storage holds payload only
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[w_wp1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== sv/scp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the command parser, bound to the top level.
module scp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [7:0]  i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);
    import scp_pkg::*;

    // Hold a stalled word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("result word changed while stalled");

    // Reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // Single-write targets always close with last
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != TGT_SCC) |-> o_m_axis_tlast)
        else $error("single-write target without last");

    // SCC pair: even address first, odd address carries last
    a_scc_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == TGT_SCC) |->
            (o_m_axis_tlast == o_m_axis_tdata[0]))
        else $error("scc write order broken");

    // SN writes and variant selects carry a zero address
    a_sn_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && ((o_m_axis_tuser == TGT_SN) || (o_m_axis_tuser == TGT_VAR)) |->
            (o_m_axis_tdata[7:0] == 8'd0))
        else $error("sn word with nonzero address");

endmodule

bind sound_chip_command_parser_unit scp_checker u_scp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ===== test/scp_write_checker.sv =====
`timescale 1ns / 1ps
// Checker for the sound-chip command parser: predicts register writes and compares each word.
module scp_write_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // [7:0] reg_addr, [15:8] write_data,
                                     // [20:16] active_mask, [23:21] zero
    input  logic [2:0]  i_m_tuser,   // [2:0] target
    input  logic        i_m_tlast,   // last_write
    output int          o_fail_count,
    output int          o_pending,
    output int          o_writes_checked
);
    import scp_pkg::*;

    // Parser state as seen from the byte stream
    t_kind             kind;
    logic [1:0]        left;
    logic [6:0]        port;
    logic [7:0]        held;
    logic [FLAG_W-1:0] flags;

    t_result expected_writes[$];
    int      errors;
    int      checked;

    function automatic t_result make_write(t_target tgt, logic [7:0] addr,
                                           logic [7:0] data, logic last);
        t_result w;
        w.target      = tgt;
        w.reg_addr    = addr;
        w.write_data  = data;
        w.active_mask = flags;
        w.last_write  = last;
        return w;
    endfunction

    task automatic predict_writes(input logic [7:0] b);
        if (kind == K_IDLE || kind > K_NES || left == 2'd0) begin
            // Idle or inconsistent: treat the byte as a command
            kind = K_IDLE;
            left = 2'd0;
            case (b)
                CMD_SCC: begin flags[FLAG_SCC] = 1'b1; kind = K_SCC; left = 2'd3; end
                CMD_AY:  begin flags[FLAG_AY]  = 1'b1; kind = K_AY;  left = 2'd2; end
                CMD_SN:  begin flags[FLAG_SN]  = 1'b1; kind = K_SN;  left = 2'd1; end
                CMD_VAR: begin kind = K_VAR; left = 2'd1; end
                CMD_GB:  begin flags[FLAG_GB]  = 1'b1; kind = K_GB;  left = 2'd2; end
                CMD_NES: begin flags[FLAG_NES] = 1'b1; kind = K_NES; left = 2'd2; end
                default: ;
            endcase
        end else begin
            case (kind)
                K_SCC: begin
                    if (left == 2'd3) begin
                        port = 7'(b & PORT_MASK);
                        left = 2'd2;
                    end else if (left == 2'd2) begin
                        held = b;
                        left = 2'd1;
                    end else begin
                        expected_writes.push_back(make_write(TGT_SCC, {port, 1'b0}, held, 1'b0));
                        expected_writes.push_back(make_write(TGT_SCC, {port, 1'b1}, b, 1'b1));
                        kind = K_IDLE;
                        left = 2'd0;
                    end
                end
                K_SN, K_VAR: begin
                    expected_writes.push_back(make_write((kind == K_SN) ? TGT_SN : TGT_VAR,
                                                         8'h00, b, 1'b1));
                    kind = K_IDLE;
                    left = 2'd0;
                end
                default: begin
                    if (left >= 2'd2) begin
                        held = b;
                        left = 2'd1;
                    end else begin
                        expected_writes.push_back(make_write((kind == K_AY) ? TGT_AY :
                                                             (kind == K_GB) ? TGT_GB : TGT_NES,
                                                             held, b, 1'b1));
                        kind = K_IDLE;
                        left = 2'd0;
                    end
                end
            endcase
        end
    endtask

    task automatic check_write();
        t_result w;
        if (expected_writes.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected write word: tuser=%0d tdata=%h tlast=%b",
                         i_m_tuser, i_m_tdata, i_m_tlast);
            return;
        end
        w = expected_writes.pop_front();
        checked++;
        if (i_m_tuser != w.target || i_m_tdata[7:0] != w.reg_addr ||
            i_m_tdata[15:8] != w.write_data || i_m_tdata[20:16] != w.active_mask ||
            i_m_tdata[23:21] != 3'd0 || i_m_tlast != w.last_write) begin
            errors++;
            if (errors <= 10) begin
                $display("write %0d mismatch: expected tgt=%0d addr=%h data=%h mask=%h last=%b,",
                         checked, w.target, w.reg_addr, w.write_data, w.active_mask,
                         w.last_write);
                $display("    got tgt=%0d addr=%h data=%h mask=%h pad=%0d last=%b",
                         i_m_tuser, i_m_tdata[7:0], i_m_tdata[15:8],
                         i_m_tdata[20:16], i_m_tdata[23:21], i_m_tlast);
            end
        end
    endtask

    initial begin
        errors  = 0;
        checked = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            kind  = K_IDLE;
            left  = 2'd0;
            port  = 7'd0;
            held  = 8'd0;
            flags = '0;
            expected_writes.delete();
        end else begin
            // Retire the output word before predicting from the input word
            if (i_m_tvalid && i_m_tready)
                check_write();
            if (i_s_tvalid && i_s_tready)
                predict_writes(i_s_tdata);
        end
        o_fail_count     <= errors;
        o_pending        <= expected_writes.size();
        o_writes_checked <= checked;
    end

endmodule

// ===== test/sound_chip_command_parser_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the sound-chip command parser: byte stimulus, output stalls and verdict.
module sound_chip_command_parser_unit_tb;
    import scp_pkg::*;

    localparam int RANDOM_BYTES   = 700;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int fail_count;
    int pending;
    int writes_checked;

    logic [7:0] byte_stream[$];
    int         bytes_sent = 0;
    int         idle_cycles = 0;

    sound_chip_command_parser_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    scp_write_checker chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .i_m_tuser        (m_tuser),
        .i_m_tlast        (m_tlast),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_writes_checked (writes_checked)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_command();
        case ($urandom_range(0, 5))
            0: return CMD_SCC;
            1: return CMD_AY;
            2: return CMD_SN;
            3: return CMD_VAR;
            4: return CMD_GB;
            default: return CMD_NES;
        endcase
    endfunction

    // Operands lean toward command values so they get mistaken for nothing
    function automatic logic [7:0] operand_byte();
        if ($urandom_range(0, 3) == 0)
            return pick_command();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int operand_count(logic [7:0] cmd);
        if (cmd == CMD_SCC) return 3;
        if (cmd == CMD_SN || cmd == CMD_VAR) return 1;
        return 2;
    endfunction

    task automatic build_stream();
        logic [7:0] cmd;
        int         r;
        int         n;
        // Variant select before any SN write, so its flag stays clear
        byte_stream = '{8'h00, 8'hFF, CMD_VAR, 8'h00, CMD_SN, 8'hFF,
                        CMD_SCC, 8'hFF, 8'h00, 8'hFF,
                        // command bytes inside a frame are operands
                        CMD_SCC, CMD_SCC, CMD_AY, CMD_SN,
                        CMD_AY, 8'h00, 8'hFF, CMD_GB, 8'hFF, 8'h00,
                        CMD_NES, 8'hAA, 8'h55, CMD_VAR, 8'hFF};
        n = byte_stream.size() + RANDOM_BYTES;
        while (byte_stream.size() < n) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                cmd = pick_command();
                byte_stream.push_back(cmd);
                repeat (operand_count(cmd)) byte_stream.push_back(operand_byte());
            end else if (r < 9) begin
                byte_stream.push_back(8'($urandom_range(0, 255)));
            end else begin
                // truncated frame: the next frame's bytes finish it
                cmd = pick_command();
                byte_stream.push_back(cmd);
                repeat ($urandom_range(0, operand_count(cmd) - 1))
                    byte_stream.push_back(operand_byte());
            end
        end
    endtask

    initial begin
        int  idx;
        int  gap;
        bit  offering;
        bit  burst;
        build_stream();
        idx      = 0;
        gap      = 0;
        offering = 1'b0;
        burst    = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (bytes_sent < byte_stream.size()) begin
            @(posedge i_clk);
            if (s_tvalid && s_tready) begin
                bytes_sent++;
                offering = 1'b0;
                if (bytes_sent % 64 == 0)
                    burst = ($urandom_range(0, 3) == 0);
            end
            if (!offering) begin
                if (gap > 0) begin
                    gap--;
                    s_tvalid <= 1'b0;
                end else if (idx < byte_stream.size()) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= byte_stream[idx];
                    idx++;
                    offering = 1'b1;
                    gap = burst ? 0 : idle_length();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
        // Drain what is still expected, then let the pipeline settle
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d bytes into the parser and %0d register writes checked,",
                 bytes_sent, writes_checked);
        $display("with random gaps on both sides and one %0d-cycle output stall.", LONG_HOLD);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Output side: random stalls, plus one long hold that backs up the input
    initial begin
        int  hold;
        int  long_left;
        bit  long_done;
        hold      = 0;
        long_left = 0;
        long_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!long_done && bytes_sent >= 250) begin
                long_left = LONG_HOLD;
                long_done = 1'b1;
            end
            if (long_left > 0) begin
                long_left--;
                m_tready <= 1'b0;
            end else if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                    hold = idle_length();
            end
        end
    end

    // Watchdog: cycles with no word moving on either side
    initial begin
        forever begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule
